FILE: src/assert_macros.svh
// Assertion macros for the gcd block, included by binary_gcd.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/bgcd_pkg.sv
// Types and constants shared by the binary gcd block.
`default_nettype none
package bgcd_pkg;

  localparam int DEFAULT_OPERAND_BITS = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMMON,
    ST_ODD_A,
    ST_REDUCE,
    ST_SCALE
  } bgcd_state_t;

  typedef struct packed {
    logic start;
    logic take;
  } bgcd_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bgcd_stat_t;

endpackage
`default_nettype wire

FILE: src/bgcd_engine.sv
// Sequencer and shared shift/subtract datapath of the binary gcd.
`default_nettype none
module bgcd_engine #(
  parameter int OPERAND_BITS = bgcd_pkg::DEFAULT_OPERAND_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire bgcd_pkg::bgcd_cmd_t     cmd,
  input  wire logic [OPERAND_BITS-1:0] operand_x,
  input  wire logic [OPERAND_BITS-1:0] operand_y,
  output bgcd_pkg::bgcd_stat_t         stat,
  output logic [OPERAND_BITS-1:0]      result
);
  import bgcd_pkg::*;

  localparam int KW = $clog2(OPERAND_BITS);

  bgcd_state_t state, state_next;
  logic [OPERAND_BITS-1:0] a, a_next;
  logic [OPERAND_BITS-1:0] b, b_next;
  logic [KW-1:0] k, k_next;

  logic                    zero_in;
  logic                    gt;
  logic [OPERAND_BITS-1:0] sub_big;
  logic [OPERAND_BITS-1:0] sub_small;
  logic [OPERAND_BITS-1:0] diff;

  assign zero_in   = (operand_x == '0) || (operand_y == '0);
  assign gt        = a > b;
  assign sub_big   = gt ? a : b;
  assign sub_small = gt ? b : a;
  assign diff      = sub_big - sub_small;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          state_next = zero_in ? ST_SCALE : ST_COMMON;
        end
      end
      ST_COMMON: begin
        if (a[0] || b[0]) begin
          state_next = ST_ODD_A;
        end
      end
      ST_ODD_A: begin
        if (a[0]) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (b == '0) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if ((k == '0) && cmd.take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    a_next = a;
    b_next = b;
    k_next = k;
    unique case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          a_next = zero_in ? (operand_x | operand_y) : operand_x;
          b_next = operand_y;
          k_next = '0;
        end
      end
      ST_COMMON: begin
        if (!a[0] && !b[0]) begin
          a_next = a >> 1;
          b_next = b >> 1;
          k_next = k + 1'b1;
        end
      end
      ST_ODD_A: begin
        if (!a[0]) begin
          a_next = a >> 1;
        end
      end
      ST_REDUCE: begin
        if (b != '0) begin
          if (!b[0]) begin
            b_next = b >> 1;
          end else begin
            a_next = gt ? b : a;
            b_next = diff;
          end
        end
      end
      ST_SCALE: begin
        if (k != '0) begin
          a_next = a << 1;
          k_next = k - 1'b1;
        end
      end
      default: begin
        a_next = a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    a <= a_next;
    b <= b_next;
    k <= k_next;
  end

  assign stat.busy = (state != ST_IDLE);
  assign stat.done = (state == ST_SCALE) && (k == '0);
  assign result    = a;

endmodule
`default_nettype wire

FILE: src/binary_gcd.sv
// Binary gcd top level: one item at a time through a shift/subtract engine.
// When an operand is zero the engine goes straight to its scale state; otherwise
// it halves both while they share trailing zeros, strips a's other trailing zeros,
// runs reduce steps (one shift or one subtract each), then shifts back left.
// Throughput: next beat accepted once the engine hands its result to the output.
// Reset clears the sequencer and the output valid; operand registers hold data.
`default_nettype none
`include "assert_macros.svh"
module binary_gcd #(
  parameter int OPERAND_BITS = bgcd_pkg::DEFAULT_OPERAND_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [OPERAND_BITS-1:0] operand_x,
  input  wire logic [OPERAND_BITS-1:0] operand_y,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [OPERAND_BITS-1:0]      divisor_out
);
  import bgcd_pkg::*;

  bgcd_cmd_t               cmd;
  bgcd_stat_t              stat;
  logic [OPERAND_BITS-1:0] result;
  logic                    in_beat;
  logic                    take;

  assign in_stall  = stat.busy;
  assign in_beat   = in_valid && !in_stall;
  assign take      = stat.done && (!out_valid || !out_stall);
  assign cmd.start = in_beat;
  assign cmd.take  = take;

  bgcd_engine #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operand_x (operand_x),
    .operand_y (operand_y),
    .stat      (stat),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      divisor_out <= result;
    end
  end

  `ASSERT_NEXT(a_start_busy, clk, rst, in_beat, in_stall)
  `ASSERT_NEXT(a_take_valid, clk, rst, take, out_valid)
  `ASSERT_NEXT(a_take_idle, clk, rst, take, !in_stall)
  `ASSERT_SAME(a_take_busy, clk, rst, take, stat.busy)

endmodule
`default_nettype wire

FILE: sim/tb_binary_gcd.sv
// Self-checking testbench for binary_gcd: directed table, then random operand pairs.
`default_nettype none
module tb_binary_gcd;

  localparam int BITS        = bgcd_pkg::DEFAULT_OPERAND_BITS;
  localparam int ROWS        = 21;
  localparam int LIMIT       = 4000000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 200;

  typedef struct {
    logic [BITS-1:0] x;
    logic [BITS-1:0] y;
    logic [BITS-1:0] want;
    bit              known;
  } gcd_row_t;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  logic [BITS-1:0] operand_x;
  logic [BITS-1:0] operand_y;
  logic            out_valid;
  logic            out_stall;
  logic [BITS-1:0] divisor_out;

  logic            want_known;
  logic [BITS-1:0] want_value;
  logic [BITS-1:0] oldest;
  logic [BITS-1:0] gcd_due[$];
  gcd_row_t        rows[ROWS];
  int              mismatches;
  int              cycle_count;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              hold_left;
  bit              hold_request;

  binary_gcd #(.OPERAND_BITS(BITS)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operand_x  (operand_x),
    .operand_y  (operand_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .divisor_out(divisor_out)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [BITS-1:0] gcd_of(logic [BITS-1:0] x, logic [BITS-1:0] y);
    logic [BITS-1:0] a;
    logic [BITS-1:0] b;
    logic [BITS-1:0] t;
    int              shared;
    if (x == '0) return y;
    if (y == '0) return x;
    shared = 0;
    t = x | y;
    while (!t[0]) begin
      t = t >> 1;
      shared++;
    end
    a = x;
    while (!a[0]) a = a >> 1;
    b = y;
    do begin
      while (!b[0]) b = b >> 1;
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      b = b - a;
    end while (b != '0);
    return a << shared;
  endfunction

  task automatic flag_mismatch(string what, logic [BITS-1:0] got, logic [BITS-1:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic drive_beat(logic [BITS-1:0] x, logic [BITS-1:0] y, bit known,
                            logic [BITS-1:0] want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid  <= 1'b0;
      operand_x <= $urandom;
      operand_y <= $urandom;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    operand_x  <= x;
    operand_y  <= y;
    want_known <= known;
    want_value <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pick_operands(output logic [BITS-1:0] x, output logic [BITS-1:0] y);
    int          pick;
    int unsigned g;
    int unsigned s;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      x = $urandom;
      y = $urandom;
    end else if (pick < 50) begin
      g = $urandom_range(1, 65535);
      x = g * $urandom_range(0, 32'hFFFF_FFFF / g);
      y = g * $urandom_range(0, 32'hFFFF_FFFF / g);
    end else if (pick < 65) begin
      s = $urandom_range(0, BITS - 1);
      x = $urandom << s;
      y = $urandom << s;
    end else if (pick < 77) begin
      x = $urandom_range(0, 255);
      y = $urandom_range(0, 255);
    end else if (pick < 85) begin
      x = $urandom_range(0, 3) == 0 ? '0 : $urandom;
      y = $urandom_range(0, 3) == 0 ? '0 : $urandom;
      if ($urandom_range(0, 1)) x = '0;
      else y = '0;
    end else if (pick < 93) begin
      x = $urandom;
      y = $urandom_range(0, 1) ? x : x * $urandom_range(2, 9);
    end else begin
      x = (1 << $urandom_range(0, BITS - 1)) | (1 << $urandom_range(0, BITS - 1));
      y = 1 << $urandom_range(0, BITS - 1);
    end
  endtask

  task automatic run_random(int count);
    logic [BITS-1:0] x;
    logic [BITS-1:0] y;
    repeat (count) begin
      pick_operands(x, y);
      drive_beat(x, y, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (gcd_due.size() == 0) begin
          flag_mismatch("unexpected beat", divisor_out, '0);
        end else begin
          oldest = gcd_due.pop_front();
          if (divisor_out !== oldest) flag_mismatch("divisor_out", divisor_out, oldest);
        end
      end
      if (in_valid && !in_stall)
        gcd_due.push_back(want_known ? want_value : gcd_of(operand_x, operand_y));
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    operand_x     = '0;
    operand_y     = '0;
    out_stall     = 1'b0;
    want_known    = 1'b0;
    want_value    = '0;
    mismatches    = 0;
    hold_left     = 0;
    hold_request  = 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 61;

    rows = '{
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1},
      '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
      '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1},
      '{32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 1'b1},
      '{32'h0000_0001, 32'h0000_0000, 32'h0000_0001, 1'b1},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
      '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1},
      '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 1'b1},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1},
      '{32'h8000_0000, 32'h0000_0001, 32'h0000_0001, 1'b1},
      '{32'h8000_0000, 32'hC000_0000, 32'h4000_0000, 1'b1},
      '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1},
      '{32'h0000_000C, 32'h0000_0012, 32'h0000_0000, 1'b0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000, 1'b0},
      '{32'hFFFF_0000, 32'h0000_FFFF, 32'h0000_0000, 1'b0},
      '{32'hDEAD_BEEF, 32'h1234_5678, 32'h0000_0000, 1'b0},
      '{32'h0000_5400, 32'h0000_8C00, 32'h0000_0000, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_0000, 1'b0},
      '{32'h0000_0003, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < ROWS; i++) drive_beat(rows[i].x, rows[i].y, rows[i].known, rows[i].want);
    run_random(600);

    send_idle_pct = 61;
    recv_idle_pct = 27;
    run_random(600);

    // hold: let every outstanding beat drain before the next phase
    @(negedge clk);
    in_valid <= 1'b0;
    while (gcd_due.size() != 0) @(posedge clk);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    run_random(550);
    @(negedge clk);
    in_valid <= 1'b0;

    while (gcd_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
